/* rtl/dts_pkg.sv */
// Shared types and constants for the token scanner.
package dts_pkg;

    localparam int POS_WIDTH = 16;
    localparam int OFFSET_WIDTH = 32;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    localparam logic [5:0] K_END = 6'd0;
    localparam logic [5:0] K_ERROR = 6'd1;
    localparam logic [5:0] K_IDENT = 6'd2;
    localparam logic [5:0] K_NUMBER = 6'd3;
    localparam logic [5:0] K_KW0 = 6'd4;
    localparam logic [5:0] K_PLUS = 6'd12;
    localparam logic [5:0] K_MINUS = 6'd13;
    localparam logic [5:0] K_STAR = 6'd14;
    localparam logic [5:0] K_SLASH = 6'd15;
    localparam logic [5:0] K_CARET = 6'd16;
    localparam logic [5:0] K_LPAREN = 6'd17;
    localparam logic [5:0] K_RPAREN = 6'd18;
    localparam logic [5:0] K_LBRACE = 6'd19;
    localparam logic [5:0] K_RBRACE = 6'd20;
    localparam logic [5:0] K_SEMI = 6'd21;
    localparam logic [5:0] K_COMMA = 6'd22;
    localparam logic [5:0] K_EQUALS = 6'd23;
    localparam logic [5:0] K_EQ_EQ = 6'd24;
    localparam logic [5:0] K_BANG = 6'd25;
    localparam logic [5:0] K_BANG_EQ = 6'd26;
    localparam logic [5:0] K_LESS = 6'd27;
    localparam logic [5:0] K_LESS_EQ = 6'd28;
    localparam logic [5:0] K_GREATER = 6'd29;
    localparam logic [5:0] K_GREATER_EQ = 6'd30;

    // one token as it travels from scanner to output queue
    typedef struct packed {
        logic [5:0]              kind;
        logic [OFFSET_WIDTH-1:0] start;
        logic [POS_WIDTH-1:0]    length;
        logic [POS_WIDTH-1:0]    line;
        logic [POS_WIDTH-1:0]    column;
        logic [7:0]              bad;
        logic                    last;
    } token_t;

    localparam int TOKEN_BITS = $bits(token_t);

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] a,
                                                     input logic [1:0] b);
        logic [POS_WIDTH:0] s;
        s = {1'b0, a} + {{(POS_WIDTH-1){1'b0}}, b};
        return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
    endfunction

endpackage

/* rtl/dts_front.sv */
// Scanner front: classifies each byte and produces up to three tokens.
module dts_front
    import dts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    output logic [1:0]  tok_count,
    output token_t      tok0,
    output token_t      tok1,
    output token_t      tok2
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_SLASH, M_COMMENT,
        M_EQ, M_BANG, M_LESS, M_GREATER
    } mode_t;

    mode_t                   mode_reg, mode_next;
    logic [47:0]             word_reg, word_next;
    logic                    long_reg, long_next;
    logic [OFFSET_WIDTH-1:0] soff_reg, soff_next;
    logic [POS_WIDTH-1:0]    sline_reg, sline_next;
    logic [POS_WIDTH-1:0]    scol_reg, scol_next;
    logic [POS_WIDTH-1:0]    plen_reg, plen_next;
    logic [OFFSET_WIDTH-1:0] off_reg;
    logic [POS_WIDTH-1:0]    line_reg;
    logic [POS_WIDTH-1:0]    col_reg;

    token_t     t [3];
    logic [1:0] n;

    logic c_alpha, c_digit, c_blank;
    assign c_alpha = (in_byte >= 8'h61 && in_byte <= 8'h7a)
                  || (in_byte >= 8'h41 && in_byte <= 8'h5a) || in_byte == 8'h5f;
    assign c_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign c_blank = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0d
                  || in_byte == 8'h0a;

    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic lg,
                                             input logic [POS_WIDTH-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (!lg) begin
            if (len == 3 && w == 48'h6c6574) k = K_KW0;
            if (len == 2 && w == 48'h666e) k = K_KW0 + 6'd1;
            if (len == 2 && w == 48'h6966) k = K_KW0 + 6'd2;
            if (len == 4 && w == 48'h656c7365) k = K_KW0 + 6'd3;
            if (len == 5 && w == 48'h7768696c65) k = K_KW0 + 6'd4;
            if (len == 6 && w == 48'h72657475726e) k = K_KW0 + 6'd5;
            if (len == 4 && w == 48'h74727565) k = K_KW0 + 6'd6;
            if (len == 5 && w == 48'h66616c7365) k = K_KW0 + 6'd7;
        end
        return k;
    endfunction

    always_comb begin
        token_t     pend;
        logic       do_flush;
        logic [5:0] sk;
        pend = '0;
        pend.start = soff_reg;
        pend.length = plen_reg;
        pend.line = sline_reg;
        pend.column = scol_reg;
        mode_next = mode_reg;
        word_next = word_reg;
        long_next = long_reg;
        soff_next = soff_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        plen_next = plen_reg;
        n = 2'd0;
        for (int i = 0; i < 3; i++) t[i] = '0;
        do_flush = 1'b1;
        sk = K_GREATER;
        unique case (mode_reg)
            M_SLASH: sk = K_SLASH;
            M_EQ:    sk = K_EQUALS;
            M_BANG:  sk = K_BANG;
            M_LESS:  sk = K_LESS;
            default: sk = K_GREATER;
        endcase
        if (!in_end) begin
            unique case (mode_reg)
                M_IDENT: if (c_alpha || c_digit) begin
                    do_flush = 1'b0;
                    if (plen_reg < 6) word_next = {word_reg[39:0], in_byte};
                    else long_next = 1'b1;
                    plen_next = sat_inc(plen_reg, 2'd1);
                end
                M_INT: if (c_digit) begin
                    do_flush = 1'b0;
                    plen_next = sat_inc(plen_reg, 2'd1);
                end else if (in_byte == 8'h2e) begin
                    do_flush = 1'b0;
                    mode_next = M_DOT;
                end
                M_DOT: if (c_digit) begin
                    do_flush = 1'b0;
                    plen_next = sat_inc(plen_reg, 2'd2);
                    mode_next = M_FRAC;
                end
                M_FRAC: if (c_digit) begin
                    do_flush = 1'b0;
                    plen_next = sat_inc(plen_reg, 2'd1);
                end
                M_SLASH: if (in_byte == 8'h2f) begin
                    do_flush = 1'b0;
                    mode_next = M_COMMENT;
                end
                M_COMMENT: if (in_byte != 8'h0a) do_flush = 1'b0;
                M_EQ, M_BANG, M_LESS, M_GREATER: if (in_byte == 8'h3d) begin
                    do_flush = 1'b0;
                    t[0] = pend;
                    t[0].length = POS_WIDTH'(2);
                    t[0].kind = (mode_reg == M_EQ) ? K_EQ_EQ :
                                (mode_reg == M_BANG) ? K_BANG_EQ :
                                (mode_reg == M_LESS) ? K_LESS_EQ : K_GREATER_EQ;
                    n = 2'd1;
                    plen_next = POS_WIDTH'(2);
                    mode_next = M_IDLE;
                end
                default: ;
            endcase
        end
        if (do_flush) begin
            // emit whatever is pending
            unique case (mode_reg)
                M_IDENT: begin
                    t[0] = pend; t[0].kind = word_kind(word_reg, long_reg, plen_reg);
                    n = 2'd1;
                end
                M_INT, M_FRAC: begin
                    t[0] = pend; t[0].kind = K_NUMBER; n = 2'd1;
                end
                M_DOT: begin
                    t[0] = pend; t[0].kind = K_NUMBER;
                    t[1] = '0;
                    t[1].kind = K_ERROR;
                    t[1].start = off_reg - OFFSET_WIDTH'(1);
                    t[1].length = POS_WIDTH'(1);
                    t[1].line = sline_reg;
                    t[1].column = sat_inc(scol_reg, 2'd0) == POS_MAX ? POS_MAX :
                        ((({1'b0, scol_reg} + {1'b0, plen_reg}) > {1'b0, POS_MAX})
                         ? POS_MAX : POS_WIDTH'({1'b0, scol_reg} + {1'b0, plen_reg}));
                    t[1].bad = 8'h2e;
                    n = 2'd2;
                end
                M_SLASH, M_EQ, M_BANG, M_LESS, M_GREATER: begin
                    t[0] = pend; t[0].kind = sk; n = 2'd1;
                end
                default: ;
            endcase
            mode_next = M_IDLE;
            if (in_end) begin
                t[n] = '0;
                t[n].kind = K_END;
                t[n].start = off_reg;
                t[n].line = line_reg;
                t[n].column = col_reg;
                n = n + 2'd1;
            end else begin
                token_t f;
                f = '0;
                f.start = off_reg;
                f.length = POS_WIDTH'(1);
                f.line = line_reg;
                f.column = col_reg;
                soff_next = off_reg;
                sline_next = line_reg;
                scol_next = col_reg;
                plen_next = POS_WIDTH'(1);
                if (c_blank) begin
                end else if (c_alpha) begin
                    mode_next = M_IDENT;
                    word_next = {40'd0, in_byte};
                    long_next = 1'b0;
                end else if (c_digit) begin
                    mode_next = M_INT;
                end else begin
                    priority case (in_byte)
                        8'h2f: mode_next = M_SLASH;
                        8'h3d: mode_next = M_EQ;
                        8'h21: mode_next = M_BANG;
                        8'h3c: mode_next = M_LESS;
                        8'h3e: mode_next = M_GREATER;
                        default: begin
                            priority case (in_byte)
                                8'h2b: f.kind = K_PLUS;
                                8'h2d: f.kind = K_MINUS;
                                8'h2a: f.kind = K_STAR;
                                8'h5e: f.kind = K_CARET;
                                8'h28: f.kind = K_LPAREN;
                                8'h29: f.kind = K_RPAREN;
                                8'h7b: f.kind = K_LBRACE;
                                8'h7d: f.kind = K_RBRACE;
                                8'h3b: f.kind = K_SEMI;
                                8'h2c: f.kind = K_COMMA;
                                default: begin
                                    f.kind = K_ERROR;
                                    f.bad = in_byte;
                                end
                            endcase
                            t[n] = f;
                            n = n + 2'd1;
                        end
                    endcase
                end
            end
        end
        if (n != 2'd0) t[n - 2'd1].last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            word_reg <= '0;
            long_reg <= 1'b0;
            soff_reg <= '0;
            sline_reg <= POS_WIDTH'(1);
            scol_reg <= POS_WIDTH'(1);
            plen_reg <= '0;
            off_reg <= '0;
            line_reg <= POS_WIDTH'(1);
            col_reg <= POS_WIDTH'(1);
        end else if (in_valid) begin
            mode_reg <= mode_next;
            word_reg <= word_next;
            long_reg <= long_next;
            soff_reg <= soff_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            plen_reg <= plen_next;
            if (!in_end) begin
                off_reg <= off_reg + OFFSET_WIDTH'(1);
                if (in_byte == 8'h0a) begin
                    line_reg <= sat_inc(line_reg, 2'd1);
                    col_reg <= POS_WIDTH'(1);
                end else begin
                    col_reg <= sat_inc(col_reg, 2'd1);
                end
            end
        end
    end

    assign tok_count = in_valid ? n : 2'd0;
    assign tok0 = t[0];
    assign tok1 = t[1];
    assign tok2 = t[2];

endmodule

/* rtl/dts_queue.sv */
// Token queue: takes up to three tokens a cycle, hands out one on rd_ready.
module dts_queue
    import dts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] wr_count,
    input  token_t     wr0,
    input  token_t     wr1,
    input  token_t     wr2,
    output logic       space_ok,
    output logic       rd_valid,
    output token_t     rd_data,
    input  logic       rd_ready
);

    localparam int DEPTH = 8;
    localparam int AW = $clog2(DEPTH);

    token_t          mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            pop;

    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign pop = rd_valid && rd_ready;
    // room for a worst-case burst of three
    assign space_ok = cnt_reg <= (AW+1)'(DEPTH - 3);

    always_ff @(posedge aclk) begin
        if (wr_count > 2'd0) mem_reg[wp_reg] <= wr0;
        if (wr_count > 2'd1) mem_reg[wp_reg + AW'(1)] <= wr1;
        if (wr_count > 2'd2) mem_reg[wp_reg + AW'(2)] <= wr2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_reg + AW'(wr_count);
            if (pop) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_count) - (AW+1)'(pop);
        end
    end

endmodule

/* rtl/dsl_token_scanner.sv */
// Top level of the streaming token scanner.
//   channel | dir | tdata                                  | tuser | tlast
//   s_      | in  | byte_in                                | end_of_source | -
//   m_      | out | kind,start,length,line,column,bad_byte | -     | last_of_run
// A source word is taken per cycle while s_tready is high; state updates that cycle.
// Each word yields 0..3 tokens to an 8-entry queue; m_ drains one a cycle on m_tready.
// s_tready drops only while the queue holds more than five tokens.
// Reset is synchronous on aresetn low: line and column restart at 1, offset at 0.
module dsl_token_scanner
    import dts_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_in
    input  logic         s_tuser,   // end_of_source
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // kind[5:0] start[37:6] length[53:38] line[69:54]
                                    // column[85:70] bad_byte[93:86], zero fill
    output logic         m_tlast    // last_of_run
);

    logic [1:0] cnt;
    token_t     t0, t1, t2, q;

    dts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && s_tready), .in_byte(s_tdata), .in_end(s_tuser),
        .tok_count(cnt), .tok0(t0), .tok1(t1), .tok2(t2)
    );

    dts_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_count(cnt), .wr0(t0), .wr1(t1), .wr2(t2),
        .space_ok(s_tready), .rd_valid(m_tvalid), .rd_data(q), .rd_ready(m_tready)
    );

    assign m_tdata = {10'd0, q.bad, q.column, q.line, q.length, q.start, q.kind};
    assign m_tlast = q.last;

endmodule

/* test/dsl_token_scanner_check.sv */
// Checker for the token scanner: predicts tokens from accepted source words and compares.
module dsl_token_scanner_check
    import dts_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);

    typedef enum logic [3:0] {
        SC_IDLE, SC_IDENT, SC_INT, SC_DOT, SC_FRAC, SC_SLASH, SC_COMMENT,
        SC_EQ, SC_BANG, SC_LESS, SC_GREATER
    } scan_t;

    scan_t                   mode;
    logic [47:0]             word;
    logic                    too_long;
    logic [OFFSET_WIDTH-1:0] tok_off, cur_off;
    logic [POS_WIDTH-1:0]    tok_line, tok_col, tok_len, cur_line, cur_col;
    token_t                  tokens_due[$];
    token_t                  step_toks[$];

    function automatic logic [POS_WIDTH-1:0] sat_add(logic [POS_WIDTH-1:0] a, int b);
        logic [POS_WIDTH+2:0] s;
        s = (POS_WIDTH+3)'(int'(a) + b);
        return (s > POS_MAX) ? POS_MAX : s[POS_WIDTH-1:0];
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic push_tok(logic [5:0] k, logic [OFFSET_WIDTH-1:0] o,
                            logic [POS_WIDTH-1:0] len, logic [POS_WIDTH-1:0] ln,
                            logic [POS_WIDTH-1:0] col, logic [7:0] bad);
        token_t t;
        t = '{kind: k, start: o, length: len, line: ln, column: col, bad: bad, last: 1'b0};
        step_toks.push_back(t);
    endtask

    function automatic logic [5:0] word_kind();
        logic [47:0] kw [8];
        int          kl [8];
        kw = '{48'h6c6574, 48'h666e, 48'h6966, 48'h656c7365, 48'h7768696c65,
               48'h72657475726e, 48'h74727565, 48'h66616c7365};
        kl = '{3, 2, 2, 4, 5, 6, 4, 5};
        if (too_long) return K_IDENT;
        for (int k = 0; k < 8; k++)
            if (kl[k] == tok_len && kw[k] == word) return K_KW0 + 6'(k);
        return K_IDENT;
    endfunction

    task automatic flush_pending();
        case (mode)
            SC_IDENT: push_tok(word_kind(), tok_off, tok_len, tok_line, tok_col, 0);
            SC_INT, SC_FRAC: push_tok(K_NUMBER, tok_off, tok_len, tok_line, tok_col, 0);
            SC_DOT: begin
                push_tok(K_NUMBER, tok_off, tok_len, tok_line, tok_col, 0);
                push_tok(K_ERROR, cur_off - 1, 1, tok_line, sat_add(tok_col, tok_len), ".");
            end
            SC_SLASH: push_tok(K_SLASH, tok_off, tok_len, tok_line, tok_col, 0);
            SC_EQ: push_tok(K_EQUALS, tok_off, tok_len, tok_line, tok_col, 0);
            SC_BANG: push_tok(K_BANG, tok_off, tok_len, tok_line, tok_col, 0);
            SC_LESS: push_tok(K_LESS, tok_off, tok_len, tok_line, tok_col, 0);
            SC_GREATER: push_tok(K_GREATER, tok_off, tok_len, tok_line, tok_col, 0);
            default: ;
        endcase
        mode = SC_IDLE;
    endtask

    task automatic begin_token(logic [7:0] c);
        logic [5:0] k;
        mode = SC_IDLE;
        tok_off = cur_off;
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = 1;
        k = K_END;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
        if (is_alpha(c)) begin
            mode = SC_IDENT;
            word = {40'd0, c};
            too_long = 0;
            return;
        end
        if (is_digit(c)) begin
            mode = SC_INT;
            return;
        end
        case (c)
            "/": mode = SC_SLASH;
            "=": mode = SC_EQ;
            "!": mode = SC_BANG;
            "<": mode = SC_LESS;
            ">": mode = SC_GREATER;
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "^": k = K_CARET;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            default: push_tok(K_ERROR, cur_off, 1, cur_line, cur_col, c);
        endcase
        if (k != K_END) push_tok(k, cur_off, 1, cur_line, cur_col, 0);
    endtask

    // returns early when the byte extends the pending token or completes a two-byte operator
    task automatic scan_byte(logic [7:0] c);
        logic [5:0] k;
        case (mode)
            SC_IDENT:
                if (is_alpha(c) || is_digit(c)) begin
                    if (tok_len < 6) word = {word[39:0], c};
                    else too_long = 1;
                    tok_len = sat_add(tok_len, 1);
                    return;
                end
            SC_INT: begin
                if (is_digit(c)) begin
                    tok_len = sat_add(tok_len, 1);
                    return;
                end
                if (c == ".") begin
                    mode = SC_DOT;
                    return;
                end
            end
            SC_DOT:
                if (is_digit(c)) begin
                    tok_len = sat_add(tok_len, 2);
                    mode = SC_FRAC;
                    return;
                end
            SC_FRAC:
                if (is_digit(c)) begin
                    tok_len = sat_add(tok_len, 1);
                    return;
                end
            SC_SLASH:
                if (c == "/") begin
                    mode = SC_COMMENT;
                    return;
                end
            SC_COMMENT: begin
                if (c != 8'h0a) return;
                mode = SC_IDLE;
            end
            SC_EQ, SC_BANG, SC_LESS, SC_GREATER:
                if (c == "=") begin
                    k = (mode == SC_EQ) ? K_EQ_EQ : (mode == SC_BANG) ? K_BANG_EQ :
                        (mode == SC_LESS) ? K_LESS_EQ : K_GREATER_EQ;
                    push_tok(k, tok_off, 2, tok_line, tok_col, 0);
                    mode = SC_IDLE;
                    return;
                end
            default: mode = SC_IDLE;
        endcase
        flush_pending();
        begin_token(c);
    endtask

    task automatic predict(logic [7:0] c, logic eos);
        token_t t;
        step_toks.delete();
        if (eos) begin
            flush_pending();
            push_tok(K_END, cur_off, 0, cur_line, cur_col, 0);
        end else begin
            scan_byte(c);
            cur_off = cur_off + 1;
            if (c == 8'h0a) begin
                cur_line = sat_add(cur_line, 1);
                cur_col = 1;
            end else begin
                cur_col = sat_add(cur_col, 1);
            end
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            t = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            tokens_due.push_back(t);
        end
    endtask

    task automatic compare_token(token_t exp_t, token_t got);
        if (got !== exp_t) begin
            errors++;
            $display("%0t mismatch: expected kind=%0d start=%0d len=%0d line=%0d col=%0d bad=%h last=%b",
                     $time, exp_t.kind, exp_t.start, exp_t.length, exp_t.line,
                     exp_t.column, exp_t.bad, exp_t.last);
            $display("%0t            actual kind=%0d start=%0d len=%0d line=%0d col=%0d bad=%h last=%b",
                     $time, got.kind, got.start, got.length, got.line, got.column,
                     got.bad, got.last);
        end
    endtask

    always @(posedge aclk) begin
        token_t got;
        if (!aresetn) begin
            mode = SC_IDLE;
            word = '0;
            too_long = 0;
            tok_off = '0;
            tok_line = 1;
            tok_col = 1;
            tok_len = '0;
            cur_off = '0;
            cur_line = 1;
            cur_col = 1;
            tokens_due.delete();
            errors = 0;
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{kind: m_tdata[5:0], start: m_tdata[37:6], length: m_tdata[53:38],
                        line: m_tdata[69:54], column: m_tdata[85:70],
                        bad: m_tdata[93:86], last: m_tlast};
                if (tokens_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected token: expected none, actual kind=%0d start=%0d",
                             $time, got.kind, got.start);
                end else begin
                    compare_token(tokens_due.pop_front(), got);
                end
            end
            if (s_tvalid && s_tready) predict(s_tdata, s_tuser);
            pending = tokens_due.size();
        end
    end

endmodule

/* test/dsl_token_scanner_test.sv */
// Testbench top for the token scanner: stimulus, idling, watchdog and verdict.
module dsl_token_scanner_test;
    import dts_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           quiet_cycles = 0;
    bit           hold_off = 0;
    bit           stim_done = 0;
    logic [8:0]   src_words[$];   // {end_of_source, byte}

    always #5 aclk = ~aclk;

    dsl_token_scanner uut (.*);

    dsl_token_scanner_check checker_i (.*);

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src_words.push_back({1'b0, s[i]});
    endtask

    task automatic add_fragment();
        string frags[] = '{"let", "fn", "if", "else", "while", "return", "true", "false",
                           "x", "foo_12", "returned", "abcdefghij", "_", "Z9", "0", "42",
                           "3.14", "7.", "12.5.6", "==", "!=", "<=", ">=", "=", "!", "<",
                           ">", "/", "// note\n", "+", "-", "*", "^", "(", ")", "{", "}",
                           ";", ",", " ", "\t", "\r", "\n", "@", "#"};
        add_text(frags[$urandom_range(0, frags.size() - 1)]);
        if ($urandom_range(0, 2) == 0) add_text(" ");
    endtask

    // sender: bursts with random gaps
    task automatic send_all();
        int burst;
        while (src_words.size() > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && src_words.size() > 0) begin
                s_tvalid <= 1;
                {s_tuser, s_tdata} <= src_words.pop_front();
                do @(posedge aclk); while (!s_tready);
                burst--;
                @(negedge aclk);
            end
            s_tvalid <= 0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    endtask

    // receiver stall pattern
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) m_tready <= 0;
            else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: keywords, numbers, dot cases, operator pairs, comment, odd bytes
        add_text("let fn if else while return true false\n");
        add_text("a_Z9 0 9.5 3. 7.x == != <= >= = ! < > / + - * ^ ( ) { } ; ,");
        add_text("// skip @#\n");
        src_words.push_back({1'b0, 8'h00});
        src_words.push_back({1'b0, 8'hff});
        src_words.push_back({1'b0, 8'h80});
        src_words.push_back({1'b0, 8'h7f});
        add_text("12.");
        src_words.push_back(9'h100);
        src_words.push_back(9'h100);
        send_all();

        // pressure: receiver holds off while sender keeps offering
        hold_off = 1;
        fork
            begin
                repeat (150) @(negedge aclk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 15; i++) add_text("; ");
                send_all();
            end
        join

        // random: mostly well-formed fragments, some noise bytes and end words
        while (src_words.size() < 50) begin
            case ($urandom_range(0, 9))
                0: src_words.push_back({1'b0, 8'($urandom_range(0, 255))});
                1: src_words.push_back(9'h100);
                default: add_fragment();
            endcase
        end
        src_words.push_back(9'h100);
        send_all();

        while (pending > 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
